>>> hdl/tmcl_pkg.sv
`timescale 1ns / 1ps

package tmcl_pkg;

  // Results per request never exceed this, whatever the level limit.
  localparam int RESULT_LIMIT = 16;

  // Widths fixed by the word layout.
  localparam int FMT_W  = 8;
  localparam int DIM_W  = 15;
  localparam int LCNT_W = 5;
  localparam int IDX_W  = 4;
  localparam int BYTE_W = 33;
  localparam int BPP_W  = 8;
  // Row bytes and level size inside the datapath.
  localparam int ROW_W  = 20;
  localparam int SZ_W   = ROW_W + DIM_W;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_PLAIN   = 2'd0;
  localparam kind_t KIND_BLOCK8  = 2'd1;
  localparam kind_t KIND_BLOCK16 = 2'd2;
  localparam kind_t KIND_PAIR    = 2'd3;

  typedef struct packed {
    logic [FMT_W-1:0]  format_code;
    logic [DIM_W-1:0]  base_width;
    logic [DIM_W-1:0]  base_height;
    logic [LCNT_W-1:0] level_count;
    logic [BYTE_W-1:0] data_bytes;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]  level_index;
    logic [DIM_W-1:0]  level_width;
    logic [DIM_W-1:0]  level_height;
    logic [BYTE_W-1:0] level_offset;
    logic [BYTE_W-1:0] level_bytes;
    logic              layout_error;
    logic              last_level;
  } res_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic size_en;
    logic mul_en;
    logic emit;
  } cmd_t;

  // Datapath to controller, valid in the check state.
  typedef struct packed {
    logic err;
    logic last;
  } status_t;

  function automatic kind_t fmt_kind(input logic [FMT_W-1:0] f);
    kind_t k;
    k = KIND_PLAIN;
    if (f == 8'd68 || f == 8'd69) begin
      k = KIND_PAIR;
    end else if ((f >= 8'd70 && f <= 8'd72) || (f >= 8'd79 && f <= 8'd81)) begin
      k = KIND_BLOCK8;
    end else if ((f >= 8'd73 && f <= 8'd78) || (f >= 8'd82 && f <= 8'd84) ||
                 (f >= 8'd94 && f <= 8'd99)) begin
      k = KIND_BLOCK16;
    end
    return k;
  endfunction

  // Bits per pixel for plain formats; zero means no size rule.
  function automatic logic [BPP_W-1:0] fmt_bits(input logic [FMT_W-1:0] f);
    logic [BPP_W-1:0] b;
    b = 8'd0;
    if (f >= 8'd1 && f <= 8'd4) begin
      b = 8'd128;
    end else if (f >= 8'd5 && f <= 8'd8) begin
      b = 8'd96;
    end else if (f >= 8'd9 && f <= 8'd22) begin
      b = 8'd64;
    end else if (f >= 8'd23 && f <= 8'd47) begin
      b = 8'd32;
    end else if (f >= 8'd48 && f <= 8'd59) begin
      b = 8'd16;
    end else if (f >= 8'd60 && f <= 8'd65) begin
      b = 8'd8;
    end else if (f == 8'd66) begin
      b = 8'd1;
    end else if (f == 8'd67) begin
      b = 8'd32;
    end else if (f == 8'd85 || f == 8'd86) begin
      b = 8'd16;
    end else if (f >= 8'd87 && f <= 8'd93) begin
      b = 8'd32;
    end
    return b;
  endfunction

endpackage

>>> hdl/tmcl_chan_if.sv
`timescale 1ns / 1ps

interface tmcl_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/tmcl_dp.sv
`timescale 1ns / 1ps

module tmcl_dp #(
  parameter int MAX_LEVELS    = 16,
  parameter int MAX_DIMENSION = 16384
) (
  input  logic              clk,
  input  tmcl_pkg::req_t    req,
  input  tmcl_pkg::cmd_t    cmd,
  output tmcl_pkg::status_t status,
  output tmcl_pkg::res_t    res
);
  import tmcl_pkg::*;

  localparam int LVL_LIM = (MAX_LEVELS < RESULT_LIMIT) ? MAX_LEVELS : RESULT_LIMIT;
  localparam logic [DIM_W+1:0]  MAXD     = (DIM_W+2)'(MAX_DIMENSION);
  localparam logic [LCNT_W-1:0] LVL_LIM_V = LCNT_W'(LVL_LIM);

  kind_t             kind_r;
  logic [BPP_W-1:0]  bpp_r;
  logic [DIM_W-1:0]  w_r, h_r;
  logic [IDX_W-1:0]  idx_r, last_idx_r;
  logic [BYTE_W-1:0] avail_r, off_r;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [DIM_W-1:0]  rows_r, rows_nxt;
  logic [SZ_W-1:0]   size_r;
  res_t              res_r;

  logic [DIM_W-1:0]    w_clamp, h_clamp, w_half, h_half;
  logic [LCNT_W-1:0]   lcnt;
  logic [SZ_W:0]       end_sum;
  logic                err;
  logic                last;
  logic [DIM_W+BPP_W:0] row_bits;

  // saturate request fields
  always_comb begin
    w_clamp = ({2'b00, req.base_width} > MAXD) ? DIM_W'(MAXD) : req.base_width;
    h_clamp = ({2'b00, req.base_height} > MAXD) ? DIM_W'(MAXD) : req.base_height;
    lcnt = (req.level_count == '0) ? LCNT_W'(1) : req.level_count;
    if (lcnt > LVL_LIM_V) lcnt = LVL_LIM_V;
  end

  // row bytes and row count for the current level
  always_comb begin
    row_bits = (DIM_W+BPP_W+1)'(w_r) * (DIM_W+BPP_W+1)'(bpp_r) +
               (DIM_W+BPP_W+1)'(7);
    unique case (kind_r)
      KIND_PAIR: begin
        row_nxt  = ROW_W'((({1'b0, w_r} + (DIM_W+1)'(1)) >> 1)) << 2;
        rows_nxt = h_r;
      end
      KIND_BLOCK8: begin
        row_nxt  = ROW_W'((({2'b00, w_r} + (DIM_W+2)'(3)) >> 2)) << 3;
        rows_nxt = DIM_W'((({2'b00, h_r} + (DIM_W+2)'(3)) >> 2));
      end
      KIND_BLOCK16: begin
        row_nxt  = ROW_W'((({2'b00, w_r} + (DIM_W+2)'(3)) >> 2)) << 4;
        rows_nxt = DIM_W'((({2'b00, h_r} + (DIM_W+2)'(3)) >> 2));
      end
      default: begin
        row_nxt  = ROW_W'(row_bits >> 3);
        rows_nxt = h_r;
      end
    endcase
  end

  // end of level against available bytes, and the next level's halved sizes
  always_comb begin
    end_sum = (SZ_W+1)'(off_r) + (SZ_W+1)'(size_r);
    err     = (size_r == '0) || (end_sum > (SZ_W+1)'(avail_r));
    last    = err || (idx_r == last_idx_r);
    w_half  = (w_r[DIM_W-1:1] > (DIM_W-1)'(1)) ? DIM_W'(w_r[DIM_W-1:1]) : DIM_W'(1);
    h_half  = (h_r[DIM_W-1:1] > (DIM_W-1)'(1)) ? DIM_W'(h_r[DIM_W-1:1]) : DIM_W'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r     <= fmt_kind(req.format_code);
      bpp_r      <= fmt_bits(req.format_code);
      w_r        <= w_clamp;
      h_r        <= h_clamp;
      idx_r      <= '0;
      last_idx_r <= IDX_W'(lcnt - LCNT_W'(1));
      avail_r    <= req.data_bytes;
      off_r      <= '0;
    end else if (cmd.emit) begin
      w_r   <= w_half;
      h_r   <= h_half;
      idx_r <= idx_r + IDX_W'(1);
      off_r <= BYTE_W'(end_sum);
    end
    if (cmd.size_en) begin
      row_r  <= row_nxt;
      rows_r <= rows_nxt;
    end
    if (cmd.mul_en) begin
      size_r <= row_r * rows_r;
    end
    if (cmd.emit) begin
      res_r.level_index  <= idx_r;
      res_r.level_width  <= w_r;
      res_r.level_height <= h_r;
      res_r.level_offset <= off_r;
      res_r.level_bytes  <= size_r[BYTE_W-1:0];
      res_r.layout_error <= err;
      res_r.last_level   <= last;
    end
  end

  assign status.err  = err;
  assign status.last = last;
  assign res         = res_r;

endmodule

>>> hdl/tmcl_ctrl.sv
`timescale 1ns / 1ps

module tmcl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  tmcl_pkg::status_t status,
  output tmcl_pkg::cmd_t    cmd
);
  import tmcl_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SIZE  = 2'd1;
  localparam logic [1:0] ST_MUL   = 2'd2;
  localparam logic [1:0] ST_CHECK = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_vld_r, out_vld_nxt;
  logic       emit;

  // result register free, or emptied at this edge
  assign emit = (state_r == ST_CHECK) && (!out_vld_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_SIZE;
      ST_SIZE:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_CHECK;
      ST_CHECK: if (emit) state_nxt = status.last ? ST_IDLE : ST_SIZE;
      default:  state_nxt = ST_IDLE;
    endcase
    out_vld_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // no word is taken while reset is held
  assign in_ready    = rst_n && (state_r == ST_IDLE);
  assign out_valid   = out_vld_r;
  assign cmd.load    = in_valid && in_ready;
  assign cmd.size_en = (state_r == ST_SIZE);
  assign cmd.mul_en  = (state_r == ST_MUL);
  assign cmd.emit    = emit;

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    emit && status.last |=> in_ready)
    else $error("run did not end after last word");

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    emit && status.err |-> status.last)
    else $error("error word not flagged last");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new request taken mid-run");

  a_rise_after_check: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r == ST_CHECK))
    else $error("result raised outside check state");

endmodule

>>> hdl/texture_mip_chain_layout_unit.sv
`timescale 1ns / 1ps

// Mip chain layout unit.
// in_req (sink) takes one request word: format code, base width and height,
// level count (0 means 1) and the texel bytes available. out_res (source)
// returns one word per mip level: index, width, height, byte offset, byte
// size, an error flag and a last flag. The run stops at the first level whose
// size is zero or which overruns the data; that word carries both flags.
// Each level passes through three steps: row size, size multiply, then offset
// add/compare into the result register. The unit takes no new request until
// the last word of the current one is loaded, and in_req.ready is high only
// between requests. The result register holds one word: if out_res stalls,
// the unit waits in its check step and resumes when the word is taken. Once
// the last word is loaded the next request may be taken while that word
// still waits. Reset (rst_n low, synchronous) returns the unit to idle, holds
// in_req.ready low and drops out_res.valid; a request already in progress is
// lost.
module texture_mip_chain_layout_unit #(
  parameter int MAX_LEVELS    = 16,
  parameter int MAX_DIMENSION = 16384
) (
  input logic   clk,
  input logic   rst_n,
  tmcl_chan_if.sink   in_req,
  tmcl_chan_if.source out_res
);
  import tmcl_pkg::*;

  cmd_t    cmd;
  status_t status;
  res_t    res;

  // sequencing: idle / size / multiply / check
  tmcl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // per-level size, offset and the result register
  tmcl_dp #(
    .MAX_LEVELS    (MAX_LEVELS),
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_dp (
    .clk    (clk),
    .req    (in_req.data),
    .cmd    (cmd),
    .status (status),
    .res    (res)
  );

  assign out_res.data = res;

endmodule
